### hw/rtl/pfgb_pkg.sv
package pfgb_pkg;

	// Default geometry
	localparam int FB_WIDTH   = 128;
	localparam int FB_HEIGHT  = 64;
	localparam int GLYPH_BITS = 16;

	// Configuration port
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic [1:0] REG_INVERT  = 2'd0;
	localparam logic [1:0] REG_GWIDTH  = 2'd1;
	localparam logic [1:0] REG_GHEIGHT = 2'd2;

	localparam logic [4:0] GWIDTH_RESET  = 5'd11;
	localparam logic [5:0] GHEIGHT_RESET = 6'd18;

	// Operation codes
	localparam logic [2:0] MODE_PIXEL  = 3'd0;
	localparam logic [2:0] MODE_FILL   = 3'd1;
	localparam logic [2:0] MODE_CURSOR = 3'd2;
	localparam logic [2:0] MODE_GLYPH  = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	// Fill patterns
	localparam logic [7:0] FILL_SET   = 8'hFF;
	localparam logic [7:0] FILL_CLEAR = 8'h00;

	typedef struct packed {
		logic       invert;
		logic [4:0] glyph_width;
		logic [5:0] glyph_height;
	} cfg_t;

endpackage

### hw/rtl/pfgb_ram.sv
module pfgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/pfgb_cfg.sv
module pfgb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfgb_pkg::CFG_AW-1:0]   paddr,
	input  logic [pfgb_pkg::CFG_DW-1:0]   pwdata,
	output logic [pfgb_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	output pfgb_pkg::cfg_t                cfg
);

	pfgb_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert       <= 1'b0;
			cfg_q.glyph_width  <= pfgb_pkg::GWIDTH_RESET;
			cfg_q.glyph_height <= pfgb_pkg::GHEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				pfgb_pkg::REG_INVERT:  cfg_q.invert       <= pwdata[0];
				pfgb_pkg::REG_GWIDTH:  cfg_q.glyph_width  <= pwdata[4:0];
				pfgb_pkg::REG_GHEIGHT: cfg_q.glyph_height <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pfgb_pkg::REG_INVERT:  prdata = 32'(cfg_q.invert);
			pfgb_pkg::REG_GWIDTH:  prdata = 32'(cfg_q.glyph_width);
			pfgb_pkg::REG_GHEIGHT: prdata = 32'(cfg_q.glyph_height);
			default:               prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/page_framebuffer_glyph_blitter_core.sv
// Monochrome page-packed framebuffer with pixel, fill, cursor, glyph-row and
// byte-read commands. Byte x + (y/8)*FB_WIDTH holds pixel (x, y) at bit y%8.
// Issue a command by raising start while busy is low; every command returns
// exactly one transfer on read_byte/status, marked by done for a single cycle.
// The receiver cannot stall: sample the result in the cycle done is high.
// Per command: set cursor, rejected commands and unused modes are answered
// straight from idle; read byte passes through setup, read-address and
// read-data states; draw pixel and glyph row pass through setup and draw, a
// glyph row drawing no column when glyph_width is zero or the row lies below
// the screen, with one read-modify-write of a framebuffer byte per column,
// pipelined through the single read port and single write port of the store;
// fill sweeps every byte, one byte per cycle. After reset the block sweeps the
// store to zero with busy high; configuration writes are taken at all times but
// must be done while no command is in flight.
module page_framebuffer_glyph_blitter_core #(
	parameter int FB_WIDTH   = pfgb_pkg::FB_WIDTH,
	parameter int FB_HEIGHT  = pfgb_pkg::FB_HEIGHT,
	parameter int GLYPH_BITS = pfgb_pkg::GLYPH_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  mode,
	input  logic [7:0]                  x,
	input  logic [7:0]                  y,
	input  logic                        color,
	input  logic [15:0]                 glyph_row,
	input  logic                        last_row,
	// result channel
	output logic                        done,
	output logic [7:0]                  read_byte,
	output logic                        status,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfgb_pkg::CFG_AW-1:0] paddr,
	input  logic [pfgb_pkg::CFG_DW-1:0] pwdata,
	output logic [pfgb_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);

	localparam int DEPTH = FB_WIDTH * FB_HEIGHT / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int GB    = GLYPH_BITS;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [8:0]    W9        = 9'(FB_WIDTH);
	localparam logic [8:0]    H9        = 9'(FB_HEIGHT);
	// single lit column: a plain pixel is drawn as a one-column glyph
	localparam logic [GB-1:0] PIX_BITS  = {1'b1, {(GB - 1){1'b0}}};

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_SETUP,
		S_DRAW,
		S_RD_ADDR,
		S_RD_DATA
	} state_t;

	pfgb_pkg::cfg_t cfg;

	// control state
	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic [7:0]    fill_q;
	logic [7:0]    cursor_col_q;
	logic [7:0]    cursor_row_q;
	logic [5:0]    gri_q;
	logic [4:0]    col_q;
	logic          v_s1;
	logic          done_q;
	logic          status_q;
	logic [7:0]    read_byte_q;

	// command payload
	logic [2:0]    mode_q;
	logic          color_q;
	logic          last_q;
	logic [7:0]    px_q;
	logic [8:0]    py_q;
	logic [GB-1:0] shift_q;
	logic [AW-1:0] base_q;
	logic [4:0]    n_q;
	logic [AW-1:0] addr_s1;
	logic          set_s1;

	// store ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic          accept;
	logic          x_off;
	logic          y_off;
	logic          fit_bad;
	logic          issue;
	logic          pix_on;
	logic [7:0]    bit_mask;
	logic [16:0]   base_full;

	pfgb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfgb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	// range and fit checks on the incoming command
	assign x_off   = ({1'b0, x} >= W9);
	assign y_off   = ({1'b0, y} >= H9);
	assign fit_bad = (({1'b0, cursor_col_q} + 9'(cfg.glyph_width)) >= W9) ||
		(({1'b0, cursor_row_q} + 9'(cfg.glyph_height)) >= H9);

	// shared address unit: page base plus column offset
	assign base_full = 17'(py_q[8:3]) * 17'(FB_WIDTH) + 17'(px_q);
	assign ram_raddr = base_q + AW'(col_q);

	// column issue and per-column colour
	assign issue    = (state_q == S_DRAW) && (col_q < n_q);
	assign pix_on   = ~(shift_q[GB-1] ^ color_q) ^ cfg.invert;
	assign bit_mask = 8'd1 << py_q[2:0];

	// write side: modify the byte read in the previous cycle, or sweep during clear and fill
	assign ram_we    = v_s1 || (state_q == S_CLEAR) || (state_q == S_FILL);
	assign ram_waddr = v_s1 ? addr_s1 : cnt_q;
	assign ram_wdata = v_s1 ? (set_s1 ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask))
		: fill_q;

	// sequencer: state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			fill_q       <= pfgb_pkg::FILL_CLEAR;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			gri_q        <= '0;
			col_q        <= '0;
			v_s1         <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			read_byte_q  <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			case (state_q)
				S_CLEAR: begin
					// power-on sweep: no transfer at its end
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_ADDR) begin
						cnt_q    <= '0;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						status_q    <= 1'b0;
						read_byte_q <= '0;
						case (mode)
							pfgb_pkg::MODE_PIXEL: begin
								if (x_off || y_off) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else begin
									state_q <= S_SETUP;
								end
							end
							pfgb_pkg::MODE_FILL: begin
								fill_q  <= color ? pfgb_pkg::FILL_SET : pfgb_pkg::FILL_CLEAR;
								state_q <= S_FILL;
							end
							pfgb_pkg::MODE_CURSOR: begin
								cursor_col_q <= x;
								cursor_row_q <= y;
								gri_q        <= '0;
								done_q       <= 1'b1;
							end
							pfgb_pkg::MODE_GLYPH: begin
								if (fit_bad) begin
									// reject whole glyph; restart row count on its last row
									done_q   <= 1'b1;
									status_q <= 1'b1;
									if (last_row) begin
										gri_q <= '0;
									end
								end else begin
									state_q <= S_SETUP;
								end
							end
							pfgb_pkg::MODE_READ: begin
								if (x_off || y_off) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else begin
									state_q <= S_SETUP;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= 1'b1;
							end
						endcase
					end
				end
				S_SETUP: begin
					col_q   <= '0;
					state_q <= (mode_q == pfgb_pkg::MODE_READ) ? S_RD_ADDR : S_DRAW;
				end
				S_DRAW: begin
					if (issue) begin
						col_q <= col_q + 5'd1;
					end else if (!v_s1) begin
						// last write has drained: finish and, after a glyph's last row, move the text cursor
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= 1'b0;
						if (mode_q == pfgb_pkg::MODE_GLYPH) begin
							if (last_q) begin
								cursor_col_q <= cursor_col_q + 8'(cfg.glyph_width);
								gri_q        <= '0;
							end else begin
								gri_q <= gri_q + 6'd1;
							end
						end
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					state_q     <= S_IDLE;
					done_q      <= 1'b1;
					status_q    <= 1'b0;
					read_byte_q <= ram_rdata;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command payload and column pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			color_q <= color;
			last_q  <= last_row;
			if (mode == pfgb_pkg::MODE_GLYPH) begin
				px_q    <= cursor_col_q;
				py_q    <= {1'b0, cursor_row_q} + 9'(gri_q);
				shift_q <= glyph_row[GB-1:0];
			end else begin
				px_q    <= x;
				py_q    <= {1'b0, y};
				shift_q <= PIX_BITS;
			end
		end
		if (state_q == S_SETUP) begin
			base_q <= base_full[AW-1:0];
			// a glyph row below the screen is clipped entirely
			if (mode_q == pfgb_pkg::MODE_PIXEL) begin
				n_q <= 5'd1;
			end else if (py_q >= H9) begin
				n_q <= '0;
			end else begin
				n_q <= cfg.glyph_width;
			end
		end
		if (issue) begin
			shift_q <= shift_q << 1;
			addr_s1 <= ram_raddr;
			set_s1  <= pix_on;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_byte = read_byte_q;

	// a result only follows an accepted command or work in progress
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("done without a command");

	// idle block leaves the store untouched
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("store written while idle");

	// column counter never runs past the row length
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAW) |-> (col_q <= n_q))
		else $error("column counter overran");

	// a rejected command returns no data
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (read_byte == 8'd0))
		else $error("rejected command returned data");

	// pixel writes belong to the draw sequence only
	a_rmw_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_DRAW))
		else $error("pixel write outside draw");

endmodule
